// ----- design/gdps_pkg.sv -----
// Shared types, constants and the sine gain table for the granular delay pitch shifter.
package gdps_pkg;

	// default parameter values
	localparam int BUFFER_DEPTH_DEF  = 8192;
	localparam int WINDOW_LENGTH_DEF = 4096;
	localparam int SAMPLE_WIDTH_DEF  = 24;

	// fixed formats
	localparam int PHASE_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int GAIN_W     = 17;
	localparam int MUL_B_W    = 18;
	localparam int SINE_IDX_W = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [GAIN_W-1:0] UNITY = 17'h10000;
	localparam int RND_BIAS = 32768;

	// multiplier-accumulator defaults (24-bit samples)
	localparam int MAC_A_W_DEF   = 33;
	localparam int MAC_ACC_W_DEF = 52;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN   = 1'd1;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DA,
		S_DB,
		S_GA,
		S_GB,
		S_TAL0,
		S_TAL1,
		S_TAR0,
		S_TAR1,
		S_TBL0,
		S_TBL1,
		S_TBR0,
		S_TBR1,
		S_WL0,
		S_WL1,
		S_WR0,
		S_WR1,
		S_OL0,
		S_OL1,
		S_OR0,
		S_OR1,
		S_DONE
	} state_t;

	typedef struct packed {
		logic en;    // update accumulator this cycle
		logic load;  // start a new sum instead of adding
		logic bias;  // start the sum at one half LSB of the Q16 result
	} mac_ctl_t;

	// sin(k*pi/32) in Q16, k = 0..16; anything past the top reads unity
	function automatic logic [GAIN_W-1:0] sine_q16(input logic [SINE_IDX_W-1:0] k);
		logic [GAIN_W-1:0] v;
		unique case (k)
			5'd0:    v = 17'd0;
			5'd1:    v = 17'd6424;
			5'd2:    v = 17'd12785;
			5'd3:    v = 17'd19024;
			5'd4:    v = 17'd25080;
			5'd5:    v = 17'd30893;
			5'd6:    v = 17'd36410;
			5'd7:    v = 17'd41576;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd50660;
			5'd10:   v = 17'd54491;
			5'd11:   v = 17'd57798;
			5'd12:   v = 17'd60547;
			5'd13:   v = 17'd62714;
			5'd14:   v = 17'd64277;
			5'd15:   v = 17'd65220;
			default: v = UNITY;
		endcase
		return v;
	endfunction

endpackage

// ----- design/gdps_mac.sv -----
// Shared signed multiply-accumulate unit used by the sequencer for every product.
module gdps_mac #(
	parameter int A_W   = gdps_pkg::MAC_A_W_DEF,
	parameter int ACC_W = gdps_pkg::MAC_ACC_W_DEF
) (
	input  logic                           clk,
	input  gdps_pkg::mac_ctl_t             ctl,
	input  logic signed [A_W-1:0]          a,
	input  logic signed [gdps_pkg::MUL_B_W-1:0] b,
	output logic signed [ACC_W-1:0]        acc
);
	import gdps_pkg::*;

	localparam int PROD_W = A_W + MUL_B_W;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	assign prod   = a * b;
	assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

	always_comb begin
		if (ctl.load) begin
			base = ctl.bias ? ACC_W'(RND_BIAS) : '0;
		end else begin
			base = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + prod_x;
		end
	end

	assign acc = acc_q;

endmodule

// ----- design/granular_delay_pitch_shifter.sv -----
// Top level: stereo two-tap crossfading delay-line pitch shifter with dry/wet mix.
// The sequencer runs every product through the single shared multiply-accumulate
// unit, 20 products per stereo sample (two delays, two gains, eight
// interpolation terms, four wet terms, four mix terms); a new input word is taken
// only after the previous result has been loaded into the output register.
// Reset: arst_n clears control state, then a clearing pass zeroes every word of the
// delay memory (BUFFER_DEPTH, 8192 by default) with s_tready low; config is taken anyway.
module granular_delay_pitch_shifter #(
	parameter int BUFFER_DEPTH  = gdps_pkg::BUFFER_DEPTH_DEF,   // power of two
	parameter int WINDOW_LENGTH = gdps_pkg::WINDOW_LENGTH_DEF,  // at most BUFFER_DEPTH
	parameter int SAMPLE_WIDTH  = gdps_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// [SW-1:0] in_left, [2*SW-1:SW] in_right, upper bits zero fill
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// [SW-1:0] out_left, [2*SW-1:SW] out_right, upper bits zero fill
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gdps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gdps_pkg::PHASE_W-1:0]     cfg_data
);
	import gdps_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int TD_W   = ((2*SW+7)/8)*8;
	localparam int IDX_W  = $clog2(BUFFER_DEPTH);
	localparam int POS_W  = IDX_W + FRAC_W;
	localparam int MA_W   = (SW + 1 > PHASE_W + 1) ? SW + 1 : PHASE_W + 1;
	localparam int ACC_W  = MA_W + MUL_B_W + 1;
	localparam int WET_W  = SW + 1;
	localparam int OUT_W  = SW + 2;

	localparam logic [MUL_B_W-1:0] WIN_B = MUL_B_W'(WINDOW_LENGTH);
	localparam logic signed [OUT_W-1:0] SAT_HI = {3'b000, {(SW-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_LO = {3'b111, {(SW-1){1'b0}}};

	function automatic logic [SW-1:0] sat_out(input logic signed [OUT_W-1:0] v);
		logic [SW-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SW-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SW-1:0];
		end else begin
			r = v[SW-1:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q, state_d;

	logic [PHASE_W-1:0] step_q;
	logic [GAIN_W-1:0]  mix_q;
	logic [PHASE_W-1:0] phase_q;
	logic [IDX_W-1:0]   wi_q;
	logic [IDX_W-1:0]   clr_q;
	logic               out_vld_q;

	// delay memory: one word holds {right, left}
	logic [2*SW-1:0] mem [BUFFER_DEPTH];
	logic [2*SW-1:0] rd_q;
	logic [IDX_W-1:0] rd_addr;

	// per-item working registers
	logic [2*SW-1:0]         a0_q, a1_q, b0_q, b1_q;
	logic signed [SW-1:0]    dl_q, dr_q;
	logic signed [SW-1:0]    tap_al_q, tap_ar_q, tap_bl_q, tap_br_q;
	logic signed [WET_W-1:0] wl_q, wr_q;
	logic [SW-1:0]           ol_q;
	logic [SW-1:0]           out_l_q, out_r_q;
	logic [POS_W-1:0]        pos_a_q, pos_b_q;
	logic [GAIN_W-1:0]       ga_q, gb_q;

	// shared unit
	mac_ctl_t                  mac_ctl;
	logic signed [MA_W-1:0]    mac_a;
	logic signed [MUL_B_W-1:0] mac_b;
	logic signed [ACC_W-1:0]   acc;

	logic in_acc;
	logic out_load;

	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- taps and gains
	logic [PHASE_W-1:0]    pa, pb, qa, qb;
	logic [SINE_IDX_W-1:0] idx_a, idx_b;
	logic [FRAC_W-1:0]     gf_a, gf_b;
	logic [GAIN_W-1:0]     diff_a, diff_b;
	logic [FRAC_W-1:0]     f_a, f_b;
	logic [GAIN_W-1:0]     nf_a, nf_b;
	logic [GAIN_W-1:0]     mix_c, dry_c;
	logic [IDX_W-1:0]      i_a, i_b;

	assign pa = phase_q;
	assign pb = {~phase_q[PHASE_W-1], phase_q[PHASE_W-2:0]};  // half a cycle ahead

	// fold into the rising half so the table only covers a quarter wave
	assign qa = pa[PHASE_W-1] ? (PHASE_W'(0) - pa) : pa;
	assign qb = pb[PHASE_W-1] ? (PHASE_W'(0) - pb) : pb;

	assign idx_a = qa[31:27];
	assign idx_b = qb[31:27];
	assign gf_a  = qa[26:11];
	assign gf_b  = qb[26:11];
	// top entry reads unity on both sides, so the slope there is zero
	assign diff_a = sine_q16(idx_a + 5'd1) - sine_q16(idx_a);
	assign diff_b = sine_q16(idx_b + 5'd1) - sine_q16(idx_b);

	assign f_a  = pos_a_q[FRAC_W-1:0];
	assign f_b  = pos_b_q[FRAC_W-1:0];
	assign nf_a = UNITY - {1'b0, f_a};
	assign nf_b = UNITY - {1'b0, f_b};
	assign i_a  = pos_a_q[POS_W-1:FRAC_W];
	assign i_b  = pos_b_q[POS_W-1:FRAC_W];

	assign mix_c = (mix_q > UNITY) ? UNITY : mix_q;
	assign dry_c = UNITY - mix_c;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			mix_q  <= UNITY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PHASE_STEP: step_q <= cfg_data;
				REG_MIX_GAIN:   mix_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == IDX_W'(BUFFER_DEPTH - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_acc) state_d = S_DA;
			S_DA:    state_d = S_DB;
			S_DB:    state_d = S_GA;
			S_GA:    state_d = S_GB;
			S_GB:    state_d = S_TAL0;
			S_TAL0:  state_d = S_TAL1;
			S_TAL1:  state_d = S_TAR0;
			S_TAR0:  state_d = S_TAR1;
			S_TAR1:  state_d = S_TBL0;
			S_TBL0:  state_d = S_TBL1;
			S_TBL1:  state_d = S_TBR0;
			S_TBR0:  state_d = S_TBR1;
			S_TBR1:  state_d = S_WL0;
			S_WL0:   state_d = S_WL1;
			S_WL1:   state_d = S_WR0;
			S_WR0:   state_d = S_WR1;
			S_WR1:   state_d = S_OL0;
			S_OL0:   state_d = S_OL1;
			S_OL1:   state_d = S_OR0;
			S_OR0:   state_d = S_OR1;
			S_OR1:   state_d = S_DONE;
			S_DONE:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// operand steering for the shared unit and memory read address
	always_comb begin
		mac_ctl  = '0;
		mac_a    = '0;
		mac_b    = '0;
		rd_addr  = i_a;
		out_load = 1'b0;
		unique case (state_q)
			// delay of each tap: phase * window, integer part is d in Q16
			S_DA: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b0};
				mac_a   = $signed(MA_W'({1'b0, pa}));
				mac_b   = $signed(WIN_B);
			end
			S_DB: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b0};
				mac_a   = $signed(MA_W'({1'b0, pb}));
				mac_b   = $signed(WIN_B);
			end
			// window gains: table slope times fraction, truncated
			S_GA: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b0};
				mac_a   = $signed(MA_W'(diff_a));
				mac_b   = $signed(MUL_B_W'(gf_a));
				rd_addr = i_a;
			end
			S_GB: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b0};
				mac_a   = $signed(MA_W'(diff_b));
				mac_b   = $signed(MUL_B_W'(gf_b));
				rd_addr = i_a + IDX_W'(1);
			end
			// linear interpolation, tap A then tap B, left then right
			S_TAL0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'($signed(a0_q[SW-1:0]));
				mac_b   = $signed(MUL_B_W'(nf_a));
				rd_addr = i_b;
			end
			S_TAL1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'($signed(a1_q[SW-1:0]));
				mac_b   = $signed(MUL_B_W'(f_a));
				rd_addr = i_b + IDX_W'(1);
			end
			S_TAR0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'($signed(a0_q[2*SW-1:SW]));
				mac_b   = $signed(MUL_B_W'(nf_a));
			end
			S_TAR1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'($signed(a1_q[2*SW-1:SW]));
				mac_b   = $signed(MUL_B_W'(f_a));
			end
			S_TBL0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'($signed(b0_q[SW-1:0]));
				mac_b   = $signed(MUL_B_W'(nf_b));
			end
			S_TBL1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'($signed(b1_q[SW-1:0]));
				mac_b   = $signed(MUL_B_W'(f_b));
			end
			S_TBR0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'($signed(b0_q[2*SW-1:SW]));
				mac_b   = $signed(MUL_B_W'(nf_b));
			end
			S_TBR1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'($signed(b1_q[2*SW-1:SW]));
				mac_b   = $signed(MUL_B_W'(f_b));
			end
			// wet = tapA*gA + tapB*gB
			S_WL0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'(tap_al_q);
				mac_b   = $signed(MUL_B_W'(ga_q));
			end
			S_WL1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'(tap_bl_q);
				mac_b   = $signed(MUL_B_W'(gb_q));
			end
			S_WR0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'(tap_ar_q);
				mac_b   = $signed(MUL_B_W'(ga_q));
			end
			S_WR1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'(tap_br_q);
				mac_b   = $signed(MUL_B_W'(gb_q));
			end
			// out = dry*(1-mix) + wet*mix
			S_OL0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'(dl_q);
				mac_b   = $signed(MUL_B_W'(dry_c));
			end
			S_OL1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'(wl_q);
				mac_b   = $signed(MUL_B_W'(mix_c));
			end
			S_OR0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, bias: 1'b1};
				mac_a   = MA_W'(dr_q);
				mac_b   = $signed(MUL_B_W'(dry_c));
			end
			S_OR1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, bias: 1'b0};
				mac_a   = MA_W'(wr_q);
				mac_b   = $signed(MUL_B_W'(mix_c));
			end
			S_DONE: begin
				out_load = !out_vld_q || m_tready;
			end
			default: ;
		endcase
	end

	gdps_mac #(
		.A_W   (MA_W),
		.ACC_W (ACC_W)
	) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			phase_q   <= '0;
			wi_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (in_acc) begin
				phase_q <= phase_q + step_q;
			end
			if (out_load) begin
				wi_q      <= wi_q + IDX_W'(1);
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- delay memory
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (in_acc) begin
			// sample goes in before the taps are read: zero delay hears it
			mem[wi_q] <= s_tdata[2*SW-1:0];
		end
		rd_q <= mem[rd_addr];
	end

	// ---------------------------------------------------------------- datapath captures
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dl_q <= $signed(s_tdata[SW-1:0]);
			dr_q <= $signed(s_tdata[2*SW-1:SW]);
		end
		case (state_q)
			S_DB:   pos_a_q <= {wi_q, {FRAC_W{1'b0}}} - acc[POS_W+FRAC_W-1:FRAC_W];
			S_GA:   pos_b_q <= {wi_q, {FRAC_W{1'b0}}} - acc[POS_W+FRAC_W-1:FRAC_W];
			S_GB: begin
				ga_q <= sine_q16(idx_a) + GAIN_W'(acc[31:16]);
				a0_q <= rd_q;
			end
			S_TAL0: begin
				gb_q <= sine_q16(idx_b) + GAIN_W'(acc[31:16]);
				a1_q <= rd_q;
			end
			S_TAL1: b0_q <= rd_q;
			S_TAR0: begin
				tap_al_q <= acc[FRAC_W +: SW];
				b1_q     <= rd_q;
			end
			S_TBL0: tap_ar_q <= acc[FRAC_W +: SW];
			S_TBR0: tap_bl_q <= acc[FRAC_W +: SW];
			S_WL0:  tap_br_q <= acc[FRAC_W +: SW];
			S_WR0:  wl_q     <= acc[FRAC_W +: WET_W];
			S_OL0:  wr_q     <= acc[FRAC_W +: WET_W];
			S_OR0:  ol_q     <= sat_out(acc[FRAC_W +: OUT_W]);
			S_DONE: begin
				if (out_load) begin
					out_l_q <= ol_q;
					out_r_q <= sat_out(acc[FRAC_W +: OUT_W]);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = TD_W'({out_r_q, out_l_q});

endmodule

// ----- design/gdps_checker.sv -----
// Port-level checker for the pitch shifter, bound to the top level.
module gdps_checker #(
	parameter int SAMPLE_WIDTH = gdps_pkg::SAMPLE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

	// busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("s_tready high right after an input word");

	// memory clearing pass holds off input after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_tready)
		else $error("input taken before the clearing pass");

	// a new result only appears as the sequencer returns to ready
	a_result_with_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result word appeared while still busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

endmodule

bind granular_delay_pitch_shifter gdps_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gdps_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the stereo pitch shifter: directed and random words against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gdps_pkg::*;

	localparam int SW    = SAMPLE_WIDTH_DEF;
	localparam int DW    = ((2*SW+7)/8)*8;
	localparam int DEPTH = BUFFER_DEPTH_DEF;
	localparam int WIN   = WINDOW_LENGTH_DEF;

	// one stereo word; left lands in the low bits of tdata
	typedef struct packed {
		logic signed [SW-1:0] right;
		logic signed [SW-1:0] left;
	} stereo_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata = '0;     // [SW-1:0] in_left, [2*SW-1:SW] in_right
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;          // [SW-1:0] out_left, [2*SW-1:SW] out_right
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PHASE_STEP;
	logic [PHASE_W-1:0]   cfg_data = '0;

	granular_delay_pitch_shifter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor state: its own delay lines, write head, phase and settings.
	// Delay lines start zeroed, matching the clearing pass after reset.
	// ---------------------------------------------------------------------
	logic signed [SW-1:0] echo_left [DEPTH];
	logic signed [SW-1:0] echo_right[DEPTH];
	logic [12:0]          head = '0;
	logic [31:0]          sweep_phase = '0;
	logic [31:0]          sweep_step = '0;
	logic [16:0]          wet_share = UNITY;

	stereo_t sample_q[$];      // words waiting for the driver
	stereo_t mix_expect[$];    // predicted output words, oldest first
	stereo_t in_flight;        // word currently offered on the slave side

	bit calm = 1'b0;           // no idling on either side while set
	int send_hold = 0;
	int recv_hold = 0;
	int fail_count = 0;
	int words_in = 0;
	int words_out = 0;
	int settings_done = 0;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			echo_left[i]  = '0;
			echo_right[i] = '0;
		end
	end

	// floor((v + 1/2 LSB) / 2^16)
	function automatic longint q16_round(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic logic signed [SW-1:0] clip(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SW-1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi[SW-1:0];
		if (v < lo) return lo[SW-1:0];
		return v[SW-1:0];
	endfunction

	// sin(k*pi/32) in Q16
	function automatic longint sine_point(input int k);
		case (k)
			0:  return 0;
			1:  return 6424;
			2:  return 12785;
			3:  return 19024;
			4:  return 25080;
			5:  return 30893;
			6:  return 36410;
			7:  return 41576;
			8:  return 46341;
			9:  return 50660;
			10: return 54491;
			11: return 57798;
			12: return 60547;
			13: return 62714;
			14: return 64277;
			15: return 65220;
			default: return 65536;
		endcase
	endfunction

	// crossfade weight sin(pi*p): fold to a quarter wave, interpolate 17 points
	function automatic longint window_gain(input logic [31:0] p);
		logic [31:0] q;
		int          k;
		longint      fr;
		q  = p[31] ? 32'(32'd0 - p) : p;
		k  = int'(q[31:27]);
		fr = longint'(q[26:11]);
		if (k >= 16) return 65536;
		return sine_point(k) + (((sine_point(k+1) - sine_point(k)) * fr) >>> 16);
	endfunction

	// interpolated read at a delay of p * WIN samples behind the head
	function automatic longint tap_value(input bit right_ch, input logic [31:0] p);
		longint d;
		longint span;
		longint pos;
		longint fr;
		longint a;
		longint b;
		int     i;
		int     i1;
		span = longint'(DEPTH) <<< 16;
		d    = (longint'(p) * WIN) >>> 16;
		pos  = ((longint'(head) <<< 16) + span - d) % span;
		i    = int'(pos >>> 16);
		i1   = (i + 1) % DEPTH;
		fr   = pos & 65535;
		a    = right_ch ? echo_right[i]  : echo_left[i];
		b    = right_ch ? echo_right[i1] : echo_left[i1];
		return q16_round(a * (65536 - fr) + b * fr);
	endfunction

	// store the dry word, advance the phase, build both taps and mix
	function automatic stereo_t shift_and_mix(input stereo_t w);
		logic [31:0] pa;
		logic [31:0] pb;
		longint      ga;
		longint      gb;
		longint      wl;
		longint      wr;
		longint      m;
		stereo_t     r;
		echo_left[head]  = w.left;
		echo_right[head] = w.right;
		sweep_phase = sweep_phase + sweep_step;
		pa = sweep_phase;
		pb = sweep_phase + 32'h8000_0000;
		ga = window_gain(pa);
		gb = window_gain(pb);
		wl = q16_round(tap_value(1'b0, pa) * ga + tap_value(1'b0, pb) * gb);
		wr = q16_round(tap_value(1'b1, pa) * ga + tap_value(1'b1, pb) * gb);
		// mix above unity counts as fully wet
		m = (wet_share > UNITY) ? 65536 : longint'(wet_share);
		r.left  = clip(q16_round(longint'(w.left)  * (65536 - m) + wl * m));
		r.right = clip(q16_round(longint'(w.right) * (65536 - m) + wr * m));
		head = head + 13'd1;
		return r;
	endfunction

	task automatic report(input string chan, input logic [SW-1:0] got, input logic [SW-1:0] want);
		fail_count++;
		$display("mismatch on word %0d, %s: got %h want %h", words_out, chan, got, want);
	endtask

	// append a word to the driver's queue
	function automatic void queue_word(input stereo_t w);
		sample_q = {sample_q, w};
	endfunction

	// ---------------------------------------------------------------------
	// Slave-side driver: offers queued words, predicts on acceptance.
	// Random hold-offs are about 7% of cycles; tvalid is never withdrawn.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_hold = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				mix_expect = {mix_expect, shift_and_mix(in_flight)};
				words_in++;
			end
			if (send_hold > 0)
				send_hold--;
			else if (!calm && $urandom_range(99) == 0)
				send_hold = $urandom_range(13, 1);
			if (!s_tvalid || s_tready) begin
				if (send_hold == 0 && sample_q.size() != 0) begin
					in_flight = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= DW'(in_flight);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Master-side monitor: random back-pressure, checks each word in order.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		stereo_t got;
		stereo_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*SW-1:0];
				if (mix_expect.size() == 0) begin
					fail_count++;
					$display("output word %0d arrived with nothing predicted", words_out);
				end else begin
					want = mix_expect.pop_front();
					if (got.left !== want.left)
						report("left", got.left, want.left);
					if (got.right !== want.right)
						report("right", got.right, want.right);
				end
				words_out++;
			end
			if (recv_hold > 0)
				recv_hold--;
			else if (!calm && $urandom_range(99) == 0)
				recv_hold = $urandom_range(13, 1);
			m_tready <= (recv_hold == 0);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	function automatic stereo_t stereo(input int l, input int r);
		stereo_t w;
		w.left  = l[SW-1:0];
		w.right = r[SW-1:0];
		return w;
	endfunction

	// full-scale noise, near-rail values and quiet values
	function automatic int pick_level();
		case ($urandom_range(3))
			0, 1:    return int'($urandom);
			2:       return $urandom_range(1) ? 8388607 - int'($urandom_range(255))
			                                  : -8388608 + int'($urandom_range(255));
			default: return int'($urandom_range(8192)) - 4096;
		endcase
	endfunction

	// block until every queued word went in and every prediction came back
	task automatic settle();
		do @(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || mix_expect.size() != 0);
	endtask

	// write both registers back to back; predictor follows each handshake
	task automatic apply_settings(input logic [31:0] step, input logic [31:0] mix_word);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PHASE_STEP;
		cfg_data  <= step;
		do @(posedge clk); while (!cfg_ready);
		sweep_step = step;
		cfg_index <= REG_MIX_GAIN;
		cfg_data  <= mix_word;
		do @(posedge clk); while (!cfg_ready);
		wet_share = mix_word[16:0];
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	initial begin
		logic [31:0] step;
		logic [31:0] mix_word;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// dry only, zero step: rails and alternating bit patterns pass straight through
		apply_settings(32'd0, 32'd0);
		queue_word(stereo(8388607, -8388608));
		queue_word(stereo(-8388608, 8388607));
		queue_word(stereo(0, -1));
		queue_word(stereo(32'h0055_5555, 32'h00AA_AAAA));
		queue_word(stereo(32'h00AA_AAAA, 32'h0055_5555));
		settle();

		// tiny step, fully wet: the near tap reads the word just written
		apply_settings(32'h0001_0000, 32'h0001_0000);
		queue_word(stereo(8388607, 8388607));
		queue_word(stereo(-8388608, -8388608));
		queue_word(stereo(8388607, -8388608));
		queue_word(stereo(1, -1));
		queue_word(stereo(-8388608, 8388607));
		settle();

		// half-cycle step swaps the taps each word; mix field at its maximum
		apply_settings(32'h8000_0000, 32'h0001_FFFF);
		queue_word(stereo(8388607, 8388607));
		queue_word(stereo(8388607, -8388608));
		queue_word(stereo(-8388608, -8388608));
		queue_word(stereo(0, 0));
		settle();

		// negative step (pitch up), mix one above unity
		apply_settings(32'hFF00_0000, 32'h0001_0001);
		queue_word(stereo(8388607, -8388608));
		queue_word(stereo(-8388608, 8388607));
		queue_word(stereo(8388607, 8388607));
		queue_word(stereo(-1, 0));
		settle();

		// largest positive step, even mix
		apply_settings(32'h7FFF_FFFF, 32'h0000_8000);
		queue_word(stereo(8388607, 8388607));
		queue_word(stereo(-8388608, -8388608));
		queue_word(stereo(8388607, -8388608));
		queue_word(stereo(32'h0055_5555, 32'h00AA_AAAA));
		queue_word(stereo(0, 8388607));
		settle();

		// random settings per phase; phase 2 runs with no idling at all
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(5))
				0, 5:    step = $urandom;
				1:       step = $urandom_range(32'h0100_0000);
				2:       step = 32'(32'd0 - $urandom_range(32'h0100_0000));
				3:       step = 32'd0;
				default: step = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			endcase
			case ($urandom_range(4))
				0:       mix_word = 32'd0;
				1:       mix_word = 32'h0001_0000;
				2:       mix_word = $urandom_range(65536);
				// above unity, junk in the unused upper bits
				3:       mix_word = {15'($urandom_range(32'h7FFF)),
				                     17'($urandom_range(131071, 65537))};
				default: mix_word = {15'($urandom_range(32'h7FFF)),
				                     17'($urandom_range(65536))};
			endcase
			calm = (ph == 2);
			apply_settings(step, mix_word);
			repeat (100) queue_word(stereo(pick_level(), pick_level()));
			settle();
		end

		// catch any stray word past the pipeline latency
		repeat (40) @(posedge clk);
		$display("covered %0d input words, %0d output words, %0d register settings",
			words_in, words_out, settings_done);
		$display("phase steps from zero to half a cycle both ways, mix from dry to beyond unity");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog: clearing pass plus slowest run, with a wide margin
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
